// ===== design/brbd_pkg.sv =====
// Package for the byte ring buffer deque: request and result structs,
// operation codes and fixed field widths. No dependencies.
package brbd_pkg;

	localparam int DEPTH_DEFAULT = 256;
	localparam int CAP_W         = 9;
	localparam int BYTE_W        = 8;
	localparam int POS_W         = 8;

	typedef enum logic [1:0] {
		KIND_PUT   = 2'd0,
		KIND_GET   = 2'd1,
		KIND_UNGET = 2'd2,
		KIND_FIND  = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] data_in;
	} cmd_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_out;
		logic              ok;
		logic [POS_W-1:0]  position;
	} res_t;

endpackage

// ===== design/brbd_wrap.sv =====
// Shared ring index adder: (a + b) folded once into 0..cap-1.
// Depends on brbd_pkg.
module brbd_wrap (
	input  logic [brbd_pkg::CAP_W-1:0] a,
	input  logic [brbd_pkg::CAP_W-1:0] b,
	input  logic [brbd_pkg::CAP_W-1:0] cap,
	output logic [brbd_pkg::CAP_W-1:0] sum
);
	import brbd_pkg::*;

	logic [CAP_W:0] raw;
	logic [CAP_W:0] folded;

	always_comb begin
		raw    = {1'b0, a} + {1'b0, b};
		folded = raw - {1'b0, cap};
		if (raw >= {1'b0, cap}) begin
			sum = folded[CAP_W-1:0];
		end else begin
			sum = raw[CAP_W-1:0];
		end
	end

endmodule

// ===== design/brbd_store.sv =====
// Byte store of the ring: one write and one read a cycle, registered read data.
// Depends on brbd_pkg.
module brbd_store #(
	parameter int Depth = 256,
	parameter int AddrW = 8
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AddrW-1:0]            waddr,
	input  logic [brbd_pkg::BYTE_W-1:0] wdata,
	input  logic                        re,
	input  logic [AddrW-1:0]            raddr,
	output logic [brbd_pkg::BYTE_W-1:0] rdata
);
	import brbd_pkg::*;

	logic [BYTE_W-1:0] mem_q [Depth];
	logic [BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/byte_ring_buffer_deque.sv =====
// Top level of the byte ring buffer deque: sequencer, head/fill/capacity state,
// output register. Depends on brbd_pkg, brbd_wrap, brbd_store.
//
//   channel  signals                          moves
//   cmd      cmd_valid / cmd_ready / cmd      one request: kind, data_in
//   res      res_valid / res_ready / res      one result: data_out, ok, position
//   cfg      cfg_valid / cfg_ready / cfg_capacity   capacity write
//
// Put, unget and refused requests: calc, done; get: calc, read, done. Find: calc,
// then done on an empty buffer, else scan and compare per byte examined, then
// done; one memory read and one pass through the wrap adder per byte.
// Reset (arst_n low) empties the buffer and sets capacity to min(DEPTH, 256).
// A new request is taken while an earlier result waits in the output register.
module byte_ring_buffer_deque #(
	parameter int DEPTH = brbd_pkg::DEPTH_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	output logic                       cmd_ready,
	input  brbd_pkg::cmd_t             cmd,
	output logic                       res_valid,
	input  logic                       res_ready,
	output brbd_pkg::res_t             res,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [brbd_pkg::CAP_W-1:0] cfg_capacity
);
	import brbd_pkg::*;

	localparam int MemDepth = (DEPTH < 511) ? DEPTH : 511;
	localparam int AddrW    = (MemDepth > 1) ? $clog2(MemDepth) : 1;
	localparam int ResetCap = (DEPTH < 256) ? DEPTH : 256;
	localparam logic [CAP_W-1:0] CapTop   = CAP_W'(MemDepth);
	localparam logic [CAP_W-1:0] CapReset = CAP_W'(ResetCap);
	localparam logic [CAP_W-1:0] One      = CAP_W'(1);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_CALC = 6'b000010,
		S_READ = 6'b000100,
		S_SCAN = 6'b001000,
		S_CMP  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t             state_q;
	logic [CAP_W-1:0]   head_q;
	logic [CAP_W-1:0]   fill_q;
	logic [CAP_W-1:0]   cap_q;
	logic               out_valid_q;
	res_t               out_res_q;
	res_t               work_res_q;
	kind_t              kind_q;
	logic [BYTE_W-1:0]  byte_q;
	logic [CAP_W-1:0]   idx_q;

	logic [CAP_W-1:0]   wrap_b;
	logic [CAP_W-1:0]   wrap_y;
	logic [CAP_W-1:0]   cap_new;
	logic [CAP_W-1:0]   idx_next;
	logic               room;
	logic               empty;
	logic               mem_we;
	logic               mem_re;
	logic [AddrW-1:0]   mem_raddr;
	logic [BYTE_W-1:0]  mem_rdata;
	logic               cmd_take;
	logic               cfg_take;
	logic               out_free;
	res_t               calc_res;

	assign room      = fill_q < cap_q;
	assign empty     = fill_q == '0;
	assign idx_next  = idx_q + One;
	assign cmd_ready = state_q == S_IDLE;
	assign cfg_ready = state_q == S_IDLE;
	assign cmd_take  = cmd_valid && cmd_ready;
	assign cfg_take  = cfg_valid && cfg_ready;
	assign out_free  = !out_valid_q || res_ready;
	assign res_valid = out_valid_q;
	assign res       = out_res_q;

	always_comb begin
		if (cfg_capacity == '0) begin
			cap_new = One;
		end else if (cfg_capacity > CapTop) begin
			cap_new = CapTop;
		end else begin
			cap_new = cfg_capacity;
		end
	end

	always_comb begin
		wrap_b = idx_q;
		if (state_q == S_CALC) begin
			case (kind_q)
				KIND_PUT:   wrap_b = fill_q;
				KIND_GET:   wrap_b = One;
				KIND_UNGET: wrap_b = cap_q - One;
				default:    wrap_b = idx_q;
			endcase
		end
	end

	always_comb begin
		calc_res = '0;
		case (kind_q)
			KIND_PUT, KIND_UNGET: begin
				if (room) begin
					calc_res.data_out = byte_q;
					calc_res.ok       = 1'b1;
				end
			end
			KIND_GET: calc_res.ok = !empty;
			default: ;
		endcase
	end

	brbd_wrap u_wrap (
		.a   (head_q),
		.b   (wrap_b),
		.cap (cap_q),
		.sum (wrap_y)
	);

	assign mem_we = (state_q == S_CALC) && room
		&& ((kind_q == KIND_PUT) || (kind_q == KIND_UNGET));
	assign mem_re = ((state_q == S_CALC) && (kind_q == KIND_GET)) || (state_q == S_SCAN);
	assign mem_raddr = (state_q == S_CALC) ? head_q[AddrW-1:0] : wrap_y[AddrW-1:0];

	brbd_store #(
		.Depth (MemDepth),
		.AddrW (AddrW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wrap_y[AddrW-1:0]),
		.wdata (byte_q),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			fill_q      <= '0;
			cap_q       <= CapReset;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_take && empty) begin
				cap_q  <= cap_new;
				head_q <= '0;
			end
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && res_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_take) begin
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					state_q <= S_DONE;
					case (kind_q)
						KIND_PUT: begin
							if (room) begin
								fill_q <= fill_q + One;
							end
						end
						KIND_GET: begin
							if (!empty) begin
								head_q  <= wrap_y;
								fill_q  <= fill_q - One;
								state_q <= S_READ;
							end
						end
						KIND_UNGET: begin
							if (room) begin
								head_q <= wrap_y;
								fill_q <= fill_q + One;
							end
						end
						default: begin
							if (!empty) begin
								state_q <= S_SCAN;
							end
						end
					endcase
				end
				S_READ: state_q <= S_DONE;
				S_SCAN: state_q <= S_CMP;
				S_CMP: begin
					if (mem_rdata == byte_q || idx_next == fill_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			kind_q <= cmd.kind;
			byte_q <= cmd.data_in;
			idx_q  <= '0;
		end
		case (state_q)
			S_CALC: work_res_q <= calc_res;
			S_READ: work_res_q.data_out <= mem_rdata;
			S_CMP: begin
				if (mem_rdata == byte_q) begin
					work_res_q <= '{data_out: work_res_q.data_out, ok: 1'b1,
						position: idx_q[POS_W-1:0]};
				end else begin
					idx_q <= idx_next;
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_res_q <= work_res_q;
				end
			end
			default: ;
		endcase
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= cap_q)
		else $error("fill count above capacity");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q < cap_q)
		else $error("head index outside ring");

	a_cap_range: assert property (@(posedge clk) disable iff (!arst_n)
		cap_q != '0 && cap_q <= CapTop)
		else $error("capacity out of range");

	a_state_hot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_take_calc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |=> state_q == S_CALC)
		else $error("accepted request not started");

endmodule
